[rtl/sample_fifo_drain_alert_defines.svh]
// Assertion macros shared by the sample FIFO checker.
`ifndef SAMPLE_FIFO_DRAIN_ALERT_DEFINES_SVH
`define SAMPLE_FIFO_DRAIN_ALERT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define SFDA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during rst.
`define SFDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sfda_pkg.sv]
// Types, codes and helper functions for the sample FIFO with batch drain.
`default_nettype none

package sfda_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int NUM_SENSORS   = 4;
  localparam int READING_W     = 16;
  localparam int STAMP_W       = 32;
  localparam int FILL_W        = 7;

  localparam logic [READING_W-1:0] THRESHOLD_RESET = 16'd80;

  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic [1:0] ST_PUSHED  = 2'd0;
  localparam logic [1:0] ST_DROPPED = 2'd1;
  localparam logic [1:0] ST_DRAINED = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  typedef logic [READING_W-1:0] reading_t;

  typedef struct packed {
    reading_t [NUM_SENSORS-1:0] temps;
    logic [STAMP_W-1:0]         stamp;
  } mem_entry_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] sensor;
  } alert_hit_t;

  // Finds the lowest-numbered sensor whose reading is strictly above the threshold.
  function automatic alert_hit_t first_over(input reading_t [NUM_SENSORS-1:0] temps,
                                            input reading_t thr);
    alert_hit_t res;
    res = '0;
    for (int j = NUM_SENSORS - 1; j >= 0; j--) begin
      if (temps[j] > thr) begin
        res.hit    = 1'b1;
        res.sensor = 2'(j);
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[rtl/sample_fifo_drain_alert.sv]
// Top level of the sample FIFO: storage memory, drain sequencer and result register.
//
//   Channel   Handshake                   Payload
//   command   start / busy                op, temp0..temp3, stamp
//   result    strobe, one cycle, no stall status, out_temp0..3, out_stamp, last,
//                                         alert, alert_sensor, fill_level, max_batch
//   config    cfg_valid / cfg_ready       cfg_data (alert threshold)
//
// A push is accepted in any cycle with busy low and its result appears on the next cycle;
// pushes run back to back at one per cycle.
// A drain of N samples raises busy, reads one entry per cycle from the single-port sample
// memory, and shows its N results on consecutive cycles, each passing the drain state, the
// memory read register and the output register; busy falls with the last of them.
// A drain of an empty FIFO answers on the next cycle like a push.
// Reset clears pointers, fill count and largest batch and sets the threshold to 80; the
// memory is not cleared.
`default_nettype none

module sample_fifo_drain_alert
  import sfda_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic                 op,
  input  wire logic [READING_W-1:0] temp0,
  input  wire logic [READING_W-1:0] temp1,
  input  wire logic [READING_W-1:0] temp2,
  input  wire logic [READING_W-1:0] temp3,
  input  wire logic [STAMP_W-1:0]   stamp,
  output logic                      strobe,
  output logic [1:0]                status,
  output logic [READING_W-1:0]      out_temp0,
  output logic [READING_W-1:0]      out_temp1,
  output logic [READING_W-1:0]      out_temp2,
  output logic [READING_W-1:0]      out_temp3,
  output logic [STAMP_W-1:0]        out_stamp,
  output logic                      last,
  output logic                      alert,
  output logic [1:0]                alert_sensor,
  output logic [FILL_W-1:0]         fill_level,
  output logic [FILL_W-1:0]         max_batch,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [READING_W-1:0] cfg_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
  localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(DEPTH);
  localparam logic [OCC_W-1:0] OCC_ONE  = OCC_W'(1);

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_DRAIN = 1'b1;

  mem_entry_t        mem [DEPTH];
  mem_entry_t        rd_q;
  mem_entry_t        wr_sample;

  logic              state;
  logic [PTR_W-1:0]  write_ptr;
  logic [PTR_W-1:0]  read_ptr;
  logic [OCC_W-1:0]  occupancy;
  logic [OCC_W-1:0]  largest_batch;
  logic [READING_W-1:0] threshold;
  logic              alerted;

  logic              rd_valid;
  logic              rd_last;
  logic [OCC_W-1:0]  rd_fill;

  logic              accept;
  logic              do_push;
  logic              is_full;
  logic              rd_en;
  alert_hit_t        hit;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PTR_ONE;
  endfunction

  function automatic logic accept_simple(input logic acc, input logic o,
                                         input logic [OCC_W-1:0] occ);
    return acc && ((o == OP_PUSH) || (occ == '0));
  endfunction

  assign accept    = start && !busy;
  assign is_full   = (occupancy == OCC_FULL);
  assign do_push   = accept && (op == OP_PUSH) && !is_full;
  assign rd_en     = (state == S_DRAIN);
  assign busy      = (state == S_DRAIN) || rd_valid;
  assign cfg_ready = !busy;
  assign max_batch = FILL_W'(largest_batch);

  assign wr_sample.temps = {temp3, temp2, temp1, temp0};
  assign wr_sample.stamp = stamp;

  // The busy interlock keeps pushes and drain reads apart, so no forwarding is needed.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[write_ptr] <= wr_sample;
    end
    if (rd_en) begin
      rd_q <= mem[read_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      write_ptr     <= '0;
      read_ptr      <= '0;
      occupancy     <= '0;
      largest_batch <= '0;
      threshold     <= THRESHOLD_RESET;
      alerted       <= 1'b0;
      rd_valid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        threshold <= cfg_data;
      end
      rd_valid <= rd_en;
      if (do_push) begin
        write_ptr <= ptr_inc(write_ptr);
        occupancy <= occupancy + OCC_ONE;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && (op == OP_DRAIN) && (occupancy != '0)) begin
            state   <= S_DRAIN;
            alerted <= 1'b0;
            if (occupancy > largest_batch) begin
              largest_batch <= occupancy;
            end
          end
        end
        S_DRAIN: begin
          read_ptr  <= ptr_inc(read_ptr);
          occupancy <= occupancy - OCC_ONE;
          if (occupancy == OCC_ONE) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (rd_valid && hit.hit) begin
        alerted <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_last <= (occupancy == OCC_ONE);
      rd_fill <= occupancy - OCC_ONE;
    end
  end

  always_comb begin
    hit = first_over(rd_q.temps, threshold);
    if (alerted) begin
      hit = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= rd_valid || accept_simple(accept, op, occupancy);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_valid) begin
      status       <= ST_DRAINED;
      out_temp0    <= rd_q.temps[0];
      out_temp1    <= rd_q.temps[1];
      out_temp2    <= rd_q.temps[2];
      out_temp3    <= rd_q.temps[3];
      out_stamp    <= rd_q.stamp;
      last         <= rd_last;
      alert        <= hit.hit;
      alert_sensor <= hit.sensor;
      fill_level   <= FILL_W'(rd_fill);
    end else begin
      out_temp0    <= '0;
      out_temp1    <= '0;
      out_temp2    <= '0;
      out_temp3    <= '0;
      out_stamp    <= '0;
      last         <= 1'b1;
      alert        <= 1'b0;
      alert_sensor <= '0;
      if (op == OP_DRAIN) begin
        status     <= ST_EMPTY;
        fill_level <= '0;
      end else if (is_full) begin
        status     <= ST_DROPPED;
        fill_level <= FILL_W'(occupancy);
      end else begin
        status     <= ST_PUSHED;
        fill_level <= FILL_W'(occupancy + OCC_ONE);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/sfda_checker.sv]
// Port-level checker for the sample FIFO and its bind to the top level.
`default_nettype none
`include "sample_fifo_drain_alert_defines.svh"

module sfda_checker
  import sfda_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 start,
  input wire logic                 busy,
  input wire logic                 op,
  input wire logic                 strobe,
  input wire logic [1:0]           status,
  input wire logic                 last
);

  `SFDA_ASSERT_NEXT(a_push_answers_next, start && !busy && (op == OP_PUSH),
    strobe && (status == ST_PUSHED || status == ST_DROPPED), "push result missing")
  `SFDA_ASSERT_NEXT(a_drain_contiguous, strobe && !last, strobe && (status == ST_DRAINED),
    "gap inside a drain transfer sequence")
  `SFDA_ASSERT_NOW(a_single_result_last, strobe && (status != ST_DRAINED), last,
    "single result without last")
  `SFDA_ASSERT_NOW(a_mid_drain_busy, strobe && !last, busy, "busy low inside a drain")

endmodule

bind sample_fifo_drain_alert sfda_checker u_sfda_checker (.*);

`default_nettype wire
